@@ hdl/segment_intersection_2d_defines.svh @@
// Assertion macros for the segment intersection block.
// Used by the checker; expects clk_i and rst_ni in scope.
`ifndef SEGMENT_INTERSECTION_2D_DEFINES_SVH
`define SEGMENT_INTERSECTION_2D_DEFINES_SVH

// antecedent implies consequent, checked at every clock edge out of reset
`define SEGI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("segment_intersection_2d: check failed");

// plain invariant
`define SEGI_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("segment_intersection_2d: invariant failed");

`endif

@@ hdl/segi_pkg.sv @@
// Shared types and constants for the segment intersection block.
// No dependencies.
`default_nettype none
package segi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DIST_BITS  = 21;
  localparam int LEN_SHIFT  = 28;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int L2_W       = 2 * DIFF_W;
  localparam int ROOT_W     = (L2_W + LEN_SHIFT) / 2;
  localparam int DSH        = 14 + FRAC_BITS;
  localparam int LATENCY    = 4 + ROOT_W + 2;

  typedef enum logic [1:0] {
    OC_HIT      = 2'd0,
    OC_PARALLEL = 2'd1,
    OC_MISS     = 2'd2
  } outcome_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dy;
  } seg_in_t;

  typedef struct packed {
    outcome_e                     outcome;
    logic [DIST_BITS-1:0]         distance;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } seg_out_t;

endpackage
`default_nettype wire

@@ hdl/segi_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS stages.
// Requires num < den; depends on segi_pkg.
`default_nettype none
module segi_div import segi_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic [MAG_W-1:0] num_i,
  input  wire logic [MAG_W-1:0] den_i,
  output logic [FRAC_BITS-1:0]  quo_o
);

  logic [MAG_W-1:0]     rem_q [FRAC_BITS];
  logic [MAG_W-1:0]     den_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_q [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
    logic [MAG_W-1:0]     rem_in;
    logic [MAG_W-1:0]     den_in;
    logic [FRAC_BITS-1:0] quo_in;
    logic [MAG_W:0]       shl;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign shl = {rem_in, 1'b0};
    assign ge  = shl >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? MAG_W'(shl - {1'b0, den_in}) : shl[MAG_W-1:0];
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[FRAC_BITS-2:0], ge};
    end
  end

  assign quo_o = quo_q[FRAC_BITS-1];

endmodule
`default_nettype wire

@@ hdl/segi_isqrt.sv @@
// Pipelined integer square root of l2 * 2^LEN_SHIFT, one root bit per stage.
// Depends on segi_pkg.
`default_nettype none
module segi_isqrt import segi_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic [L2_W-1:0] l2_i,
  output logic [ROOT_W-1:0]    root_o
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_in  = RAD_W'({l2_i, LEN_SHIFT'(0)});
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_in, 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
      rem_q[k]  <= ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
      root_q[k] <= {root_in[ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule
`default_nettype wire

@@ hdl/segment_intersection_2d.sv @@
// Segment intersection: fully pipelined, accepting one transaction per cycle;
// busy is never high.
// Depth is set by the square root pipeline (one root bit per stage).
// rst_ni clears all valid bits asynchronously; payload registers are not reset.
// Depends on segi_pkg, segi_div, segi_isqrt.
`default_nettype none
module segment_intersection_2d import segi_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire seg_in_t req_i,
  output logic         done_o,
  output seg_out_t     res_o
);

  typedef struct packed {
    outcome_e                     outcome;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [DIFF_W-1:0]     abx;
    logic signed [DIFF_W-1:0]     aby;
  } side_t;

  localparam int RQ_DLY = ROOT_W - FRAC_BITS;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [COORD_BITS+3:0] v
  );
    logic signed [COORD_BITS+3:0] hi;
    logic signed [COORD_BITS+3:0] lo;
    hi = (COORD_BITS+4)'((1 << (COORD_BITS-1)) - 1);
    lo = -(COORD_BITS+4)'(1 << (COORD_BITS-1));
    if (v > hi) return hi[COORD_BITS-1:0];
    if (v < lo) return lo[COORD_BITS-1:0];
    return v[COORD_BITS-1:0];
  endfunction

  assign busy = 1'b0;

  // stage 1: differences
  logic                     v1_q;
  logic signed [DIFF_W-1:0] abx1_q, aby1_q, cdx1_q, cdy1_q, acx1_q, acy1_q;
  logic signed [COORD_BITS-1:0] ax1_q, ay1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start;
  end

  always_ff @(posedge clk_i) begin
    abx1_q <= DIFF_W'(req_i.bx) - DIFF_W'(req_i.ax);
    aby1_q <= DIFF_W'(req_i.by) - DIFF_W'(req_i.ay);
    cdx1_q <= DIFF_W'(req_i.dx) - DIFF_W'(req_i.cx);
    cdy1_q <= DIFF_W'(req_i.dy) - DIFF_W'(req_i.cy);
    acx1_q <= DIFF_W'(req_i.ax) - DIFF_W'(req_i.cx);
    acy1_q <= DIFF_W'(req_i.ay) - DIFF_W'(req_i.cy);
    ax1_q  <= req_i.ax;
    ay1_q  <= req_i.ay;
  end

  // stage 2: products
  logic                     v2_q;
  logic signed [PROD_W-1:0] p_rt0_q, p_rt1_q, p_st0_q, p_st1_q, p_dn0_q, p_dn1_q;
  logic signed [PROD_W-1:0] sqx_q, sqy_q;
  side_t                    s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    p_rt0_q <= acy1_q * cdx1_q;
    p_rt1_q <= acx1_q * cdy1_q;
    p_st0_q <= acy1_q * abx1_q;
    p_st1_q <= acx1_q * aby1_q;
    p_dn0_q <= abx1_q * cdy1_q;
    p_dn1_q <= aby1_q * cdx1_q;
    sqx_q   <= abx1_q * abx1_q;
    sqy_q   <= aby1_q * aby1_q;
    s2_q    <= '{outcome: OC_MISS, ax: ax1_q, ay: ay1_q, abx: abx1_q, aby: aby1_q};
  end

  // stage 3: cross products and squared length
  logic                      v3_q;
  logic signed [CROSS_W-1:0] rtop3_q, stop3_q, den3_q;
  logic [L2_W-1:0]           l2_q;
  side_t                     s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    rtop3_q <= CROSS_W'(p_rt0_q) - CROSS_W'(p_rt1_q);
    stop3_q <= CROSS_W'(p_st0_q) - CROSS_W'(p_st1_q);
    den3_q  <= CROSS_W'(p_dn0_q) - CROSS_W'(p_dn1_q);
    l2_q    <= L2_W'(sqx_q) + L2_W'(sqy_q);
    s3_q    <= s2_q;
  end

  // stage 4: sign normalization and classification
  logic signed [CROSS_W-1:0] rn, sn, dn;
  logic                      hit;
  outcome_e                  oc4;

  always_comb begin
    rn  = den3_q[CROSS_W-1] ? -rtop3_q : rtop3_q;
    sn  = den3_q[CROSS_W-1] ? -stop3_q : stop3_q;
    dn  = den3_q[CROSS_W-1] ? -den3_q  : den3_q;
    hit = (rn > 0) && (rn < dn) && (sn > 0) && (sn < dn);
    if (den3_q == '0) oc4 = OC_PARALLEL;
    else if (hit)     oc4 = OC_HIT;
    else              oc4 = OC_MISS;
  end

  logic             v4_q;
  logic [MAG_W-1:0] num4_q, den4_q;
  logic [L2_W-1:0]  l24_q;
  side_t            s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    num4_q <= rn[MAG_W-1:0];
    den4_q <= dn[MAG_W-1:0];
    l24_q  <= l2_q;
    s4_q   <= '{outcome: oc4, ax: s3_q.ax, ay: s3_q.ay, abx: s3_q.abx, aby: s3_q.aby};
  end

  // fraction and length pipelines
  logic [FRAC_BITS-1:0] rq_div;
  logic [ROOT_W-1:0]    len;

  segi_div u_div (
    .clk_i (clk_i),
    .num_i (num4_q),
    .den_i (den4_q),
    .quo_o (rq_div)
  );

  segi_isqrt u_isqrt (
    .clk_i  (clk_i),
    .l2_i   (l24_q),
    .root_o (len)
  );

  logic [FRAC_BITS-1:0] rq_dly_q [RQ_DLY];
  side_t                side_q   [ROOT_W];
  logic [ROOT_W-1:0]    vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[ROOT_W-2:0], v4_q};
  end

  always_ff @(posedge clk_i) begin
    rq_dly_q[0] <= rq_div;
    for (int i = 1; i < RQ_DLY; i++) rq_dly_q[i] <= rq_dly_q[i-1];
    side_q[0] <= s4_q;
    for (int i = 1; i < ROOT_W; i++) side_q[i] <= side_q[i-1];
  end

  // multiply stage
  logic                                vm_q;
  logic [ROOT_W+FRAC_BITS-1:0]         dprod_q;
  logic signed [FRAC_BITS+DIFF_W:0]    pxp_q, pyp_q;
  side_t                               sm_q;
  side_t                               s_end;
  logic [FRAC_BITS-1:0]                rq_end;

  assign s_end  = side_q[ROOT_W-1];
  assign rq_end = rq_dly_q[RQ_DLY-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else vm_q <= vld_q[ROOT_W-1];
  end

  always_ff @(posedge clk_i) begin
    dprod_q <= (ROOT_W+FRAC_BITS)'(len) * (ROOT_W+FRAC_BITS)'(rq_end);
    pxp_q   <= $signed({1'b0, rq_end}) * s_end.abx;
    pyp_q   <= $signed({1'b0, rq_end}) * s_end.aby;
    sm_q    <= s_end;
  end

  // rounding, saturation, output register
  logic [ROOT_W+FRAC_BITS:0]          dsum;
  logic [ROOT_W+FRAC_BITS-DSH:0]      dval;
  logic [DIST_BITS-1:0]               dist_sat;
  logic signed [FRAC_BITS+DIFF_W+1:0] xsum, ysum;
  logic signed [COORD_BITS+3:0]       xr, yr;
  seg_out_t                           res_d;

  always_comb begin
    dsum = (ROOT_W+FRAC_BITS+1)'(dprod_q) + (ROOT_W+FRAC_BITS+1)'(1 << (DSH-1));
    dval = dsum[ROOT_W+FRAC_BITS:DSH];
    if ((ROOT_W+FRAC_BITS-DSH+1)'(dval) > (ROOT_W+FRAC_BITS-DSH+1)'((1 << DIST_BITS) - 1))
      dist_sat = '1;
    else
      dist_sat = DIST_BITS'(dval);
    xsum = (FRAC_BITS+DIFF_W+2)'(pxp_q) + (FRAC_BITS+DIFF_W+2)'(1 << (FRAC_BITS-1));
    ysum = (FRAC_BITS+DIFF_W+2)'(pyp_q) + (FRAC_BITS+DIFF_W+2)'(1 << (FRAC_BITS-1));
    xr = (COORD_BITS+4)'(sm_q.ax) + (COORD_BITS+4)'(xsum >>> FRAC_BITS);
    yr = (COORD_BITS+4)'(sm_q.ay) + (COORD_BITS+4)'(ysum >>> FRAC_BITS);
    res_d.outcome = sm_q.outcome;
    if (sm_q.outcome == OC_HIT) begin
      res_d.distance = dist_sat;
      res_d.point_x  = sat_coord(xr);
      res_d.point_y  = sat_coord(yr);
    end else begin
      res_d.distance = '0;
      res_d.point_x  = '0;
      res_d.point_y  = '0;
    end
  end

  logic     done_q;
  seg_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= vm_q;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

@@ hdl/segi_checker.sv @@
// Port-level checks for segment_intersection_2d, bound to the top level.
// Depends on segi_pkg and segment_intersection_2d_defines.svh.
`default_nettype none
`include "segment_intersection_2d_defines.svh"
module segi_checker import segi_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire seg_in_t  req_i,
  input wire logic     done_o,
  input wire seg_out_t res_o
);

  logic in_x;
  logic miss_zero;
  logic code_ok;
  assign in_x      = ^req_i;
  assign miss_zero = res_o.distance == '0 && res_o.point_x == '0 && res_o.point_y == '0;
  assign code_ok   = res_o.outcome inside {OC_HIT, OC_PARALLEL, OC_MISS};

  `SEGI_ASSERT_ALWAYS(a_never_busy, !busy)
  `SEGI_ASSERT_IMPL(a_latency, start && !busy, ##LATENCY done_o)
  `SEGI_ASSERT_IMPL(a_no_spurious, done_o, $past(start, LATENCY) || (in_x && 1'b0))
  `SEGI_ASSERT_IMPL(a_miss_zero, done_o && res_o.outcome != OC_HIT, miss_zero)
  `SEGI_ASSERT_IMPL(a_code_ok, done_o, code_ok)

endmodule

bind segment_intersection_2d segi_checker u_segi_checker (.*);
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for segment_intersection_2d: random and directed segment pairs checked
// against a built-in fixed-point predictor. Depends on segi_pkg and the block RTL.
`timescale 1ns / 1ps
module tb_top;
  import segi_pkg::*;

  localparam int CYC_LIMIT = 5000;

  logic     clk_i, rst_ni, start, busy, done_o;
  seg_in_t  req_i;
  seg_out_t res_o;

  seg_in_t  pending_q[$];
  seg_out_t expected_q[$];
  int       mismatches, sent, received, idle_pct, n_hit, n_par, n_miss, quiet;
  bit       stim_done;

  segment_intersection_2d i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .res_o(res_o)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] interp(longint a, longint d,
                                                          longint rq);
    longint p, r;
    p = rq * d + (64'sd1 <<< (FRAC_BITS - 1));
    r = a + (p >>> FRAC_BITS);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[COORD_BITS-1:0];
  endfunction

  function automatic seg_out_t predict_crossing(seg_in_t t);
    seg_out_t o;
    longint abx, aby, cdx, cdy, acx, acy, rtop, stp, den;
    longint unsigned rq, l2, len, dist_v;
    abx = longint'(t.bx) - longint'(t.ax);
    aby = longint'(t.by) - longint'(t.ay);
    cdx = longint'(t.dx) - longint'(t.cx);
    cdy = longint'(t.dy) - longint'(t.cy);
    acx = longint'(t.ax) - longint'(t.cx);
    acy = longint'(t.ay) - longint'(t.cy);
    rtop = acy * cdx - acx * cdy;
    stp = acy * abx - acx * aby;
    den = abx * cdy - aby * cdx;
    o = '0;
    if (den == 0) begin
      o.outcome = OC_PARALLEL;
      return o;
    end
    if (den < 0) begin
      den = -den; rtop = -rtop; stp = -stp;
    end
    if (!(rtop > 0 && rtop < den && stp > 0 && stp < den)) begin
      o.outcome = OC_MISS;
      return o;
    end
    rq = (unsigned'(rtop) << FRAC_BITS) / unsigned'(den);
    l2 = abx * abx + aby * aby;
    len = int_sqrt(l2 << LEN_SHIFT);
    dist_v = (len * rq + (64'd1 << (DSH - 1))) >> DSH;
    if (dist_v > (64'd1 << DIST_BITS) - 1) dist_v = (64'd1 << DIST_BITS) - 1;
    o.outcome = OC_HIT;
    o.distance = dist_v[DIST_BITS-1:0];
    o.point_x = interp(t.ax, abx, rq);
    o.point_y = interp(t.ay, aby, rq);
    return o;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic seg_in_t make_pair(int ax, ay, bx, by, cx, cy, dx, dy);
    seg_in_t t;
    t.ax = 16'(ax); t.ay = 16'(ay); t.bx = 16'(bx); t.by = 16'(by);
    t.cx = 16'(cx); t.cy = 16'(cy); t.dx = 16'(dx); t.dy = 16'(dy);
    return t;
  endfunction

  // mostly crossing pairs: build AB, pick a point near its midpoint, run CD through that point
  function automatic seg_in_t rand_pair();
    seg_in_t t;
    int px, py, vx, vy, span;
    if ($urandom_range(0, 3) == 0)
      return make_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(), rand_coord());
    span = ($urandom_range(0, 3) == 0) ? 16000 : 400;
    t.ax = 16'($urandom_range(0, 2 * span) - span);
    t.ay = 16'($urandom_range(0, 2 * span) - span);
    t.bx = 16'($urandom_range(0, 2 * span) - span);
    t.by = 16'($urandom_range(0, 2 * span) - span);
    px = (int'(t.ax) + int'(t.bx)) / 2 + $urandom_range(0, 20) - 10;
    py = (int'(t.ay) + int'(t.by)) / 2 + $urandom_range(0, 20) - 10;
    vx = $urandom_range(0, 2 * span) - span;
    vy = $urandom_range(0, 2 * span) - span;
    t.cx = 16'(px - vx); t.cy = 16'(py - vy);
    t.dx = 16'(px + vx); t.dy = 16'(py + vy);
    return t;
  endfunction

  initial begin
    pending_q.push_back(make_pair(0, 0, 160, 160, 0, 160, 160, 0));
    pending_q.push_back(make_pair(0, 0, 160, 0, 0, 16, 160, 16));
    pending_q.push_back(make_pair(0, 0, 0, 0, 5, 5, 9, 9));
    pending_q.push_back(make_pair(0, 0, 160, 160, 200, 0, 400, -50));
    pending_q.push_back(make_pair(0, 0, 160, 160, 0, 160, 80, 80));
    pending_q.push_back(make_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                                  16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
    pending_q.push_back(make_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                                  16'h8000, 16'h8000, 16'h7fff, 16'h7fff));
    pending_q.push_back(make_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                  16'hffff, 16'hffff, 16'hffff, 16'hffff));
    pending_q.push_back(make_pair(16'h8000, 0, 16'h7fff, 1, 16'h8001, 16'h8000,
                                  16'h8001, 16'h7fff));
    pending_q.push_back(make_pair(0, 0, 160, 0, 80, -16, 80, 0));
    pending_q.push_back(make_pair(0, 0, 160, 0, 159, -16, 160, 16));
    pending_q.push_back(make_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                                  16'h8001, 16'h8000, 16'h8000, 16'h7fff));
    for (int i = 0; i < 1950; i++) pending_q.push_back(rand_pair());
  end

  initial begin
    rst_ni = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
  end

  always @(posedge clk_i) begin
    idle_pct <= (sent < 500) ? 0 : (sent < 1000) ? 57 : (sent < 1500) ? 0 : 28;
  end

  // driver
  initial begin
    start = 0;
    req_i = '0;
    stim_done = 0;
  end
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_q.push_back(predict_crossing(req_i));
        sent <= sent + 1;
        void'(pending_q.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 && $urandom_range(1, 100) > idle_pct) begin
          start <= 1;
          req_i <= pending_q[0];
        end else begin
          start <= 0;
        end
      end
      if (pending_q.size() == 0) stim_done <= 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    seg_out_t exp_r;
    if (rst_ni && done_o) begin
      received <= received + 1;
      if (expected_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected transaction: %p", res_o);
      end else begin
        exp_r = expected_q.pop_front();
        case (exp_r.outcome)
          OC_HIT: n_hit++;
          OC_PARALLEL: n_par++;
          default: n_miss++;
        endcase
        if (res_o !== exp_r) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", exp_r, res_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= CYC_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    mismatches = 0; sent = 0; received = 0; quiet = 0;
    n_hit = 0; n_par = 0; n_miss = 0;
    wait (stim_done && expected_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (expected_q.size() != 0) mismatches = mismatches + expected_q.size();
    $display("%0d pairs sent, %0d results: %0d crossings, %0d parallel, %0d apart",
             sent, received, n_hit, n_par, n_miss);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hdl
hdl/segi_pkg.sv
hdl/segi_div.sv
hdl/segi_isqrt.sv
hdl/segment_intersection_2d.sv
hdl/segi_checker.sv
sim/tb_top.sv
